### rtl/core/dtq_pkg.sv
// Shared types, codes and helpers of the deadline timer queue.
package dtq_pkg;

	localparam int DEFAULT_HEAP_DEPTH = 32;
	localparam int MAX_POPS           = 32;
	localparam int POP_CNT_W          = 6;

	typedef enum logic [1:0] {
		OP_SCHEDULE = 2'd0,
		OP_CANCEL   = 2'd1,
		OP_TICK     = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_SCHED_ACK  = 3'd0,
		KIND_CANCEL_ACK = 3'd1,
		KIND_FIRED      = 3'd2,
		KIND_SKIPPED    = 3'd3,
		KIND_IDLE_TICK  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP,
		ST_SCAN,
		ST_POP,
		ST_MET,
		ST_MOVE,
		ST_DOWN,
		ST_REINS,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		CO_NONE,
		CO_LOAD,
		CO_UP,
		CO_DOWN,
		CO_CANCEL
	} cell_op_t;

	typedef struct packed {
		logic [47:0] deadline;
		logic [15:0] entry_id;
		logic [31:0] period;
		logic        repeats;
		logic        cancelled;
	} entry_t;

	// Swap decision of the cursor cell
	typedef struct packed {
		logic up;
		logic left;
		logic right;
	} dir_t;

	typedef struct packed {
		cell_op_t op;
		dir_t     dir;
	} cell_ctrl_t;

	function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? {48{1'b1}} : s[47:0];
	endfunction

endpackage

### rtl/core/dtq_if.sv
// Command and event channel interfaces of the deadline timer queue.
interface dtq_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] start_delay;
	logic [31:0] repeat_period;
	logic        periodic;
	logic [15:0] task_id;
	logic [15:0] elapsed_ms;

	modport source (output valid, operation, start_delay, repeat_period, periodic, task_id,
		elapsed_ms, input ready);
	modport sink (input valid, operation, start_delay, repeat_period, periodic, task_id,
		elapsed_ms, output ready);
endinterface

interface dtq_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] result_id;
	logic [1:0]  status;
	logic [47:0] drift_ms;
	logic        repeats;
	logic [31:0] executed_count;
	logic [47:0] drift_peak;
	logic [47:0] drift_sum;
	logic        last;

	modport source (output valid, kind, result_id, status, drift_ms, repeats,
		executed_count, drift_peak, drift_sum, last, input ready);
	modport sink (input valid, kind, result_id, status, drift_ms, repeats,
		executed_count, drift_peak, drift_sum, last, output ready);
endinterface

### rtl/core/dtq_cell.sv
// One heap slot: holds an entry and swaps it with its parent or a child.
module dtq_cell #(
	parameter int K          = 0,
	parameter int HEAP_DEPTH = dtq_pkg::DEFAULT_HEAP_DEPTH,
	parameter int IW         = $clog2(HEAP_DEPTH),
	parameter int CW         = $clog2(HEAP_DEPTH + 1)
) (
	input  logic               clk,
	input  dtq_pkg::cell_ctrl_t ctrl,
	input  logic [IW-1:0]      cur,
	input  logic [CW-1:0]      cnt,
	input  dtq_pkg::entry_t    din,
	input  dtq_pkg::entry_t    par,
	input  dtq_pkg::entry_t    lch,
	input  dtq_pkg::entry_t    rch,
	output dtq_pkg::entry_t    q,
	output dtq_pkg::dir_t      dec
);
	import dtq_pkg::*;

	localparam int  L     = 2 * K + 1;
	localparam int  R     = 2 * K + 2;
	localparam bit  HAS_P = (K > 0);
	localparam bit  HAS_L = (L < HEAP_DEPTH);
	localparam bit  HAS_R = (R < HEAP_DEPTH);
	localparam int  PK    = (K > 0) ? (K - 1) / 2 : 0;
	localparam bit  IS_L  = (K % 2) == 1;

	entry_t q_q;
	logic   is_cur;
	logic   lv;
	logic   rv;

	assign is_cur = (cur == IW'(K));

	always_comb begin
		lv = HAS_L && (cnt > CW'(L)) && (lch.deadline < q_q.deadline);
		rv = HAS_R && (cnt > CW'(R)) &&
			(rch.deadline < (lv ? lch.deadline : q_q.deadline));
		dec.up    = is_cur && (ctrl.op == CO_UP) && HAS_P && (q_q.deadline < par.deadline);
		dec.right = is_cur && (ctrl.op == CO_DOWN) && rv;
		dec.left  = is_cur && (ctrl.op == CO_DOWN) && lv && !rv;
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CO_LOAD: begin
				if (is_cur) q_q <= din;
			end
			CO_CANCEL: begin
				if (is_cur) q_q.cancelled <= 1'b1;
			end
			CO_UP: begin
				if (dec.up) q_q <= par;
				else if (HAS_L && cur == IW'(L) && ctrl.dir.up) q_q <= lch;
				else if (HAS_R && cur == IW'(R) && ctrl.dir.up) q_q <= rch;
			end
			CO_DOWN: begin
				if (dec.left) q_q <= lch;
				else if (dec.right) q_q <= rch;
				else if (HAS_P && cur == IW'(PK) && IS_L && ctrl.dir.left) q_q <= par;
				else if (HAS_P && cur == IW'(PK) && !IS_L && ctrl.dir.right) q_q <= par;
			end
			default: begin
			end
		endcase
	end

	assign q = q_q;

endmodule

### rtl/core/deadline_timer_queue.sv
// Top level of the deadline timer queue: sequencer, counters and the row of heap cells.
// Deadline timer queue. Entries sit in a binary min-heap kept in a tree-wired row of
// HEAP_DEPTH cells, ordered by 48-bit deadline with strict less-than sifting. One
// transaction is taken at a time. A schedule loads the entry into the first free cell and
// sifts it up one heap level at a time (at most log2(HEAP_DEPTH) levels), then gives the
// result. A cancel walks live entries one per cycle until it finds the id or passes the
// last one. A tick checks the root once per pop; each popped entry is replaced by the last
// entry, which sifts down, and a periodic entry is then reinserted and sifts up; a tick
// that pops nothing gives an idle result. The cells make one sift step per cycle, and a
// result that finds the output register still full holds the sequencer until it drains.
// Results leave through an output register, so the next transaction is taken while the
// final result still waits.
module deadline_timer_queue #(
	parameter int HEAP_DEPTH = dtq_pkg::DEFAULT_HEAP_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	dtq_cmd_if.sink    cmd,
	dtq_evt_if.source  evt
);
	import dtq_pkg::*;

	localparam int IW = $clog2(HEAP_DEPTH);
	localparam int CW = $clog2(HEAP_DEPTH + 1);

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      cur_q;
	logic [CW-1:0]      scan_q;
	logic [POP_CNT_W-1:0] npop_q;
	logic [47:0]        now_q;
	logic [15:0]        next_id_q;
	logic [31:0]        popped_q;
	logic [47:0]        dsum_q;
	logic [47:0]        dpeak_q;
	op_t                op_q;
	logic [15:0]        tid_q;
	logic               hold_q;
	logic               back_q;
	entry_t             pop_q;

	// pending result
	kind_t              pkind_q;
	logic [15:0]        pid_q;
	status_t            pstat_q;
	logic [47:0]        pdrift_q;
	logic               prep_q;

	// output register
	logic               ovalid_q;
	logic               olast_q;
	kind_t              okind_q;
	logic [15:0]        oid_q;
	status_t            ostat_q;
	logic [47:0]        odrift_q;
	logic               orep_q;
	logic [31:0]        oexec_q;
	logic [47:0]        opeak_q;
	logic [47:0]        osum_q;

	entry_t             ent [HEAP_DEPTH];
	dir_t               cdec [HEAP_DEPTH];
	dir_t               dir_or;
	cell_ctrl_t         cctrl;
	logic [IW-1:0]      ccur;
	entry_t             cdin;
	entry_t             rd;
	logic [IW-1:0]      rd_idx;

	logic               accept;
	logic               full;
	logic               slot_free;
	logic               push;
	logic               push_last;
	logic               due;
	logic               scan_hit;
	logic [31:0]        reins_per;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign full      = (count_q == CW'(HEAP_DEPTH));
	assign slot_free = !ovalid_q || evt.ready;
	assign rd        = ent[rd_idx];
	assign due       = (npop_q < POP_CNT_W'(MAX_POPS)) && (count_q != '0) &&
		(ent[0].deadline <= now_q);
	assign scan_hit  = (scan_q < count_q) && (rd.entry_id == tid_q);
	assign reins_per = (pop_q.period == '0) ? 32'd1 : pop_q.period;

	// gather the cursor cell's decision
	always_comb begin
		dir_or = '0;
		for (int i = 0; i < HEAP_DEPTH; i++) begin
			dir_or = dir_or | cdec[i];
		end
	end

	// heap cells, wired as a binary tree
	for (genvar k = 0; k < HEAP_DEPTH; k++) begin : g_cell
		localparam int PI = (k > 0) ? (k - 1) / 2 : k;
		localparam int LI = (2 * k + 1 < HEAP_DEPTH) ? 2 * k + 1 : k;
		localparam int RI = (2 * k + 2 < HEAP_DEPTH) ? 2 * k + 2 : k;
		dtq_cell #(.K(k), .HEAP_DEPTH(HEAP_DEPTH), .IW(IW), .CW(CW)) u_cell (
			.clk  (clk),
			.ctrl (cctrl),
			.cur  (ccur),
			.cnt  (count_q),
			.din  (cdin),
			.par  (ent[PI]),
			.lch  (ent[LI]),
			.rch  (ent[RI]),
			.q    (ent[k]),
			.dec  (cdec[k])
		);
	end

	// next state, cell commands, result push
	always_comb begin
		state_d   = state_q;
		cctrl.op  = CO_NONE;
		cctrl.dir = dir_or;
		ccur      = cur_q;
		rd_idx    = scan_q[IW-1:0];
		cdin      = '{deadline: add_sat48(now_q, {16'd0, cmd.start_delay}),
			entry_id: next_id_q, period: cmd.repeat_period, repeats: cmd.periodic,
			cancelled: 1'b0};
		push      = 1'b0;
		push_last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority case (op_t'(cmd.operation))
						OP_SCHEDULE: begin
							if (full) begin
								state_d = ST_EMIT;
							end else begin
								cctrl.op = CO_LOAD;
								ccur     = count_q[IW-1:0];
								state_d  = ST_UP;
							end
						end
						OP_CANCEL: state_d = ST_SCAN;
						OP_TICK:   state_d = ST_POP;
						default:   state_d = ST_EMIT;
					endcase
				end
			end
			ST_UP: begin
				cctrl.op = CO_UP;
				if (!dir_or.up) state_d = (op_q == OP_SCHEDULE) ? ST_EMIT : ST_POP;
			end
			ST_SCAN: begin
				if (scan_hit) begin
					cctrl.op = CO_CANCEL;
					ccur     = scan_q[IW-1:0];
					state_d  = ST_EMIT;
				end else if (scan_q >= count_q) begin
					state_d = ST_EMIT;
				end
			end
			ST_POP: begin
				if (hold_q) begin
					if (slot_free) begin
						push      = 1'b1;
						push_last = !due;
						state_d   = due ? ST_POP : ST_IDLE;
					end
				end else if (due) begin
					state_d = ST_MET;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_MET: begin
				state_d = (count_q != '0) ? ST_MOVE : (back_q ? ST_REINS : ST_POP);
			end
			ST_MOVE: begin
				cctrl.op = CO_LOAD;
				ccur     = '0;
				rd_idx   = count_q[IW-1:0];
				cdin     = rd;
				state_d  = ST_DOWN;
			end
			ST_DOWN: begin
				cctrl.op = CO_DOWN;
				if (!dir_or.left && !dir_or.right) state_d = back_q ? ST_REINS : ST_POP;
			end
			ST_REINS: begin
				cctrl.op = CO_LOAD;
				ccur     = count_q[IW-1:0];
				cdin     = '{deadline: add_sat48(now_q, {16'd0, reins_per}),
					entry_id: pop_q.entry_id, period: pop_q.period, repeats: 1'b1,
					cancelled: 1'b0};
				state_d  = ST_UP;
			end
			ST_EMIT: begin
				if (slot_free) begin
					push    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			now_q     <= '0;
			next_id_q <= 16'd1;
			popped_q  <= '0;
			dsum_q    <= '0;
			dpeak_q   <= '0;
			npop_q    <= '0;
			hold_q    <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			if (push) ovalid_q <= 1'b1;
			else if (evt.ready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						npop_q <= '0;
						hold_q <= 1'b0;
						if (op_t'(cmd.operation) == OP_SCHEDULE && !full) begin
							count_q   <= count_q + 1'b1;
							next_id_q <= (next_id_q == 16'hFFFF) ? 16'd1 : next_id_q + 1'b1;
						end
						if (op_t'(cmd.operation) == OP_TICK) begin
							now_q <= add_sat48(now_q, {32'd0, cmd.elapsed_ms});
						end
					end
				end
				ST_POP: begin
					if (hold_q) begin
						if (slot_free) hold_q <= 1'b0;
					end else if (due) begin
						count_q <= count_q - 1'b1;
						npop_q  <= npop_q + 1'b1;
					end
				end
				ST_MET: begin
					if (popped_q != '1) popped_q <= popped_q + 1'b1;
					dsum_q <= add_sat48(dsum_q, pdrift_q);
					if (pdrift_q > dpeak_q) dpeak_q <= pdrift_q;
					hold_q <= 1'b1;
				end
				ST_REINS: begin
					count_q <= count_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q     <= op_t'(cmd.operation);
					tid_q    <= cmd.task_id;
					scan_q   <= '0;
					pdrift_q <= '0;
					prep_q   <= 1'b0;
					pstat_q  <= STAT_OK;
					priority case (op_t'(cmd.operation))
						OP_SCHEDULE: begin
							pkind_q <= KIND_SCHED_ACK;
							pid_q   <= full ? 16'd0 : next_id_q;
							pstat_q <= full ? STAT_FULL : STAT_OK;
							cur_q   <= count_q[IW-1:0];
						end
						OP_CANCEL: begin
							pkind_q <= KIND_CANCEL_ACK;
							pid_q   <= '0;
						end
						default: begin
							pkind_q <= KIND_IDLE_TICK;
							pid_q   <= '0;
						end
					endcase
				end
			end
			ST_UP: begin
				if (dir_or.up) cur_q <= IW'((cur_q - 1'b1) >> 1);
			end
			ST_SCAN: begin
				if (scan_hit) begin
					pid_q <= tid_q;
				end else if (scan_q >= count_q) begin
					pstat_q <= STAT_NOT_FOUND;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			ST_POP: begin
				if (!hold_q && due) begin
					pop_q    <= ent[0];
					pkind_q  <= ent[0].cancelled ? KIND_SKIPPED : KIND_FIRED;
					pid_q    <= ent[0].entry_id;
					pdrift_q <= now_q - ent[0].deadline;
					prep_q   <= ent[0].repeats && !ent[0].cancelled;
					back_q   <= ent[0].repeats && !ent[0].cancelled;
				end
			end
			ST_MOVE: begin
				cur_q <= '0;
			end
			ST_DOWN: begin
				if (dir_or.left) cur_q <= IW'({1'b0, cur_q, 1'b1});
				else if (dir_or.right) cur_q <= IW'({1'b0, cur_q, 1'b0} + 2'd2);
			end
			ST_REINS: begin
				cur_q <= count_q[IW-1:0];
			end
			default: begin
			end
		endcase
		if (push) begin
			olast_q  <= push_last;
			okind_q  <= pkind_q;
			oid_q    <= pid_q;
			ostat_q  <= pstat_q;
			odrift_q <= pdrift_q;
			orep_q   <= prep_q;
			oexec_q  <= popped_q;
			opeak_q  <= dpeak_q;
			osum_q   <= dsum_q;
		end
	end

	assign evt.valid          = ovalid_q;
	assign evt.kind           = okind_q;
	assign evt.result_id      = oid_q;
	assign evt.status         = ostat_q;
	assign evt.drift_ms       = odrift_q;
	assign evt.repeats        = orep_q;
	assign evt.executed_count = oexec_q;
	assign evt.drift_peak     = opeak_q;
	assign evt.drift_sum      = osum_q;
	assign evt.last           = olast_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HEAP_DEPTH))
		else $error("heap count beyond depth");

	a_root_no_up: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP && cur_q == '0) |-> !dir_or.up)
		else $error("root asked to sift up");

	a_pop_limit: assert property (@(posedge clk) disable iff (!arst_n)
		npop_q <= POP_CNT_W'(MAX_POPS))
		else $error("pop limit exceeded");

	a_one_dir: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({dir_or.up, dir_or.left, dir_or.right}) <= 1)
		else $error("conflicting swap decisions");

endmodule
